/* hw/rtl/ebbd_pkg.sv */
// ebbd_pkg: shared types and constants of the energy band beat decimator
// band codes, register indexes, pending store sizing, controller/datapath structs
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ebbd_pkg;

   // pending store sizing
   localparam int PEND_DEPTH = 32;
   localparam int PTR_W      = $clog2(PEND_DEPTH);
   localparam int CNT_W      = $clog2(PEND_DEPTH + 1);
   localparam int SUM_W      = PTR_W + 1;

   // field widths
   localparam int TIME_W   = 32;
   localparam int ENERGY_W = 16;
   localparam int BAND_W   = 2;
   localparam int DIV_W    = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // band codes
   localparam logic [BAND_W-1:0] BAND_CALM    = 2'd0;
   localparam logic [BAND_W-1:0] BAND_NORMAL  = 2'd1;
   localparam logic [BAND_W-1:0] BAND_FRANTIC = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_LOW_THRESHOLD   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HIGH_THRESHOLD  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_SECTION     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CALM_DIVISOR    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_NORMAL_DIVISOR  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_FRANTIC_DIVISOR = 3'd5;

   // commands from the controller
   typedef struct packed {
      logic take;          // latch the request word
      logic first_beat;    // open the first section of a run
      logic new_section;   // open a new, unsettled section
      logic merge_section; // unsettled section takes the committed band
      logic set_settled;   // mark the section settled
      logic write_beat;    // append the beat to the pending store
      logic commit;        // commit the head of the pending store
      logic merge;         // commit with the committed band instead of the stored one
      logic flush_held;    // send the held word as the last one of this beat
      logic run_reset;     // return run state to reset
   } ctrl_cmd_type;

   // status back to the controller
   typedef struct packed {
      logic seen;
      logic band_diff;
      logic settled;
      logic full;
      logic empty;
      logic head_go;
      logic out_free;
      logic held_valid;
      logic last;
   } dp_status_type;

endpackage

`default_nettype wire

/* hw/rtl/energy_band_beat_decimator.sv */
// energy_band_beat_decimator: top level, controller plus datapath
// each beat runs through the controller states; output stalls can hold it
// one beat at a time: a new beat is taken only in idle; a beat that flushes the pending store
//   reads each head entry through the registered head read before it commits
// reset: synchronous, active high; the pending store needs no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module energy_band_beat_decimator (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_stall,
   input  wire  [ebbd_pkg::TIME_W-1:0]       req_beat_time,
   input  wire  [ebbd_pkg::ENERGY_W-1:0]     req_energy,
   input  wire                               req_last_beat,
   output logic                              rsp_valid,
   input  wire                               rsp_stall,
   output logic [ebbd_pkg::TIME_W-1:0]       rsp_kept_time,
   output logic [ebbd_pkg::BAND_W-1:0]       rsp_kept_band,
   output logic                              rsp_run_end,
   input  wire                               csr_valid,
   output logic                              csr_ready,
   input  wire  [ebbd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire  [ebbd_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import ebbd_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // sequencer
   ebbd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath
   ebbd_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_beat_time (req_beat_time),
      .req_energy    (req_energy),
      .req_last_beat (req_last_beat),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_kept_time (rsp_kept_time),
      .rsp_kept_band (rsp_kept_band),
      .rsp_run_end   (rsp_run_end),
      .cmd           (cmd),
      .status        (status)
   );

endmodule

`default_nettype wire

/* hw/rtl/ebbd_ctrl.sv */
// ebbd_ctrl: sequencer of the energy band beat decimator
// walks each beat through section update, store drains, write and end of run
// depends on ebbd_pkg
`timescale 1ns / 1ps
`default_nettype none

module ebbd_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  wire ebbd_pkg::dp_status_type status,
   output ebbd_pkg::ctrl_cmd_type  cmd
);
   import ebbd_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_CLASS = 4'd1;
   localparam logic [3:0] S_RD    = 4'd2;
   localparam logic [3:0] S_EV    = 4'd3;
   localparam logic [3:0] S_POST1 = 4'd4;
   localparam logic [3:0] S_FULL  = 4'd5;
   localparam logic [3:0] S_WRITE = 4'd6;
   localparam logic [3:0] S_LAST  = 4'd7;
   localparam logic [3:0] S_RESET = 4'd8;
   localparam logic [3:0] S_FLUSH = 4'd9;

   logic [3:0] state_ff, state_in;
   logic [3:0] ret_ff, ret_in;
   logic       merge_ff, merge_in;

   assign req_stall = (state_ff != S_IDLE);

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      merge_in  = merge_ff;
      cmd       = '0;
      cmd.merge = merge_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = S_CLASS;
            end
         end
         S_CLASS: begin
            if (!status.seen) begin
               cmd.first_beat = 1'b1;
               state_in       = S_FULL;
            end else if (status.band_diff) begin
               if (status.settled) begin
                  merge_in = 1'b0;
                  ret_in   = S_POST1;
               end else begin
                  cmd.merge_section = 1'b1;
                  merge_in          = 1'b1;
                  ret_in            = S_FULL;
               end
               state_in = S_RD;
            end else begin
               state_in = S_FULL;
            end
         end
         // wait for the head entry read
         S_RD: begin
            if (status.empty) begin
               state_in = ret_ff;
            end else begin
               state_in = S_EV;
            end
         end
         S_EV: begin
            if (!status.head_go) begin
               state_in = ret_ff;
            end else if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_RD;
            end
         end
         S_POST1: begin
            cmd.new_section = 1'b1;
            state_in        = S_FULL;
         end
         // a full store settles the section and drains
         S_FULL: begin
            if (status.full) begin
               cmd.set_settled = 1'b1;
               merge_in        = 1'b0;
               ret_in          = S_WRITE;
               state_in        = S_RD;
            end else begin
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            cmd.write_beat = 1'b1;
            merge_in       = 1'b0;
            ret_in         = S_LAST;
            state_in       = S_RD;
         end
         // end of run: merge an unsettled section, drain all
         S_LAST: begin
            if (status.last) begin
               merge_in        = !status.settled;
               cmd.set_settled = 1'b1;
               ret_in          = S_RESET;
               state_in        = S_RD;
            end else begin
               state_in = S_FLUSH;
            end
         end
         S_RESET: begin
            cmd.run_reset = 1'b1;
            state_in      = S_FLUSH;
         end
         S_FLUSH: begin
            if (!status.held_valid) begin
               state_in = S_IDLE;
            end else if (status.out_free) begin
               cmd.flush_held = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= S_IDLE;
         merge_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         merge_ff <= merge_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/ebbd_datapath.sv */
// ebbd_datapath: registers, pending store, divisor counter and output path
// of the energy band beat decimator
// depends on ebbd_pkg, driven by ebbd_ctrl
`timescale 1ns / 1ps
`default_nettype none

module ebbd_datapath (
   input  wire                               clock,
   input  wire                               reset,
   input  wire  [ebbd_pkg::TIME_W-1:0]       req_beat_time,
   input  wire  [ebbd_pkg::ENERGY_W-1:0]     req_energy,
   input  wire                               req_last_beat,
   input  wire                               csr_valid,
   output logic                              csr_ready,
   input  wire  [ebbd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire  [ebbd_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output logic                              rsp_valid,
   input  wire                               rsp_stall,
   output logic [ebbd_pkg::TIME_W-1:0]       rsp_kept_time,
   output logic [ebbd_pkg::BAND_W-1:0]       rsp_kept_band,
   output logic                              rsp_run_end,
   input  wire ebbd_pkg::ctrl_cmd_type       cmd,
   output ebbd_pkg::dp_status_type           status
);
   import ebbd_pkg::*;

   // configuration registers
   logic [ENERGY_W-1:0] low_thr_ff, high_thr_ff;
   logic [TIME_W-1:0]   min_sec_ff;
   logic [DIV_W-1:0]    calm_div_ff, normal_div_ff, frantic_div_ff;

   // latched request word
   logic [TIME_W-1:0] item_time_ff;
   logic [BAND_W-1:0] item_band_ff;
   logic              item_last_ff;
   logic [BAND_W-1:0] req_band;

   // run state
   logic [TIME_W-1:0] sec_start_ff;
   logic [BAND_W-1:0] sec_band_ff;
   logic              settled_ff, seen_ff, any_commit_ff;
   logic [BAND_W-1:0] committed_ff;
   logic [DIV_W-1:0]  phase_ff;

   // pending store
   logic [TIME_W-1:0] pend_time_ff [PEND_DEPTH];
   logic [BAND_W-1:0] pend_band_ff [PEND_DEPTH];
   logic [PTR_W-1:0]  head_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [TIME_W-1:0] rd_time_ff;
   logic [BAND_W-1:0] rd_band_ff;
   logic [SUM_W-1:0]  tail_sum;
   logic [PTR_W-1:0]  tail;
   logic [PTR_W-1:0]  head_next;

   // held and output words
   logic              held_valid_ff;
   logic [TIME_W-1:0] held_time_ff;
   logic [BAND_W-1:0] held_band_ff;
   logic              rsp_valid_ff;
   logic [TIME_W-1:0] rsp_time_ff;
   logic [BAND_W-1:0] rsp_band_ff;
   logic              rsp_end_ff;
   logic              out_free;

   // commit arithmetic
   logic [BAND_W-1:0] c_band;
   logic [DIV_W-1:0]  c_div;
   logic [DIV_W-1:0]  ph_a, ph_b, ph_c;
   logic              c_keep;
   logic [TIME_W-1:0] sec_len;

   function automatic logic [DIV_W-1:0] div_fix(input logic [DIV_W-1:0] d);
      div_fix = (d == '0) ? DIV_W'(1) : d;
   endfunction

   assign csr_ready = 1'b1;

   // band of the incoming beat, calm test first
   always_comb begin
      if (req_energy < low_thr_ff) begin
         req_band = BAND_CALM;
      end else if (req_energy > high_thr_ff) begin
         req_band = BAND_FRANTIC;
      end else begin
         req_band = BAND_NORMAL;
      end
   end

   // store addressing
   assign tail_sum  = SUM_W'(head_ff) + SUM_W'(count_ff);
   assign tail      = (tail_sum >= SUM_W'(PEND_DEPTH)) ?
                      PTR_W'(tail_sum - SUM_W'(PEND_DEPTH)) : PTR_W'(tail_sum);
   assign head_next = (head_ff == PTR_W'(PEND_DEPTH - 1)) ? '0 : head_ff + PTR_W'(1);

   // divisor counter step for the head entry
   always_comb begin
      c_band = cmd.merge ? committed_ff : rd_band_ff;
      case (c_band)
         BAND_CALM:    c_div = div_fix(calm_div_ff);
         BAND_FRANTIC: c_div = div_fix(frantic_div_ff);
         default:      c_div = div_fix(normal_div_ff);
      endcase
      ph_a   = (any_commit_ff && (c_band != committed_ff)) ? '0 : phase_ff;
      ph_b   = (ph_a >= c_div) ? '0 : ph_a;
      c_keep = (ph_b == '0);
      ph_c   = ((ph_b + DIV_W'(1)) >= c_div) ? '0 : ph_b + DIV_W'(1);
   end

   assign sec_len  = item_time_ff - sec_start_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // status
   always_comb begin
      status.seen       = seen_ff;
      status.band_diff  = (item_band_ff != sec_band_ff);
      status.settled    = settled_ff;
      status.full       = (count_ff == CNT_W'(PEND_DEPTH));
      status.empty      = (count_ff == '0);
      status.head_go    = cmd.merge || settled_ff || (rd_band_ff == committed_ff);
      status.out_free   = out_free;
      status.held_valid = held_valid_ff;
      status.last       = item_last_ff;
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         low_thr_ff     <= ENERGY_W'(19661);
         high_thr_ff    <= ENERGY_W'(45875);
         min_sec_ff     <= '0;
         calm_div_ff    <= DIV_W'(1);
         normal_div_ff  <= DIV_W'(1);
         frantic_div_ff <= DIV_W'(1);
      end else if (csr_valid) begin
         case (csr_index)
            REG_LOW_THRESHOLD:   low_thr_ff     <= csr_wdata[ENERGY_W-1:0];
            REG_HIGH_THRESHOLD:  high_thr_ff    <= csr_wdata[ENERGY_W-1:0];
            REG_MIN_SECTION:     min_sec_ff     <= csr_wdata[TIME_W-1:0];
            REG_CALM_DIVISOR:    calm_div_ff    <= csr_wdata[DIV_W-1:0];
            REG_NORMAL_DIVISOR:  normal_div_ff  <= csr_wdata[DIV_W-1:0];
            REG_FRANTIC_DIVISOR: frantic_div_ff <= csr_wdata[DIV_W-1:0];
            default: ;
         endcase
      end
   end

   // request word
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         item_time_ff <= req_beat_time;
         item_band_ff <= req_band;
         item_last_ff <= req_last_beat;
      end
   end

   // section and commit state
   always_ff @(posedge clock) begin
      if (reset || cmd.run_reset) begin
         sec_start_ff  <= '0;
         sec_band_ff   <= BAND_NORMAL;
         settled_ff    <= 1'b0;
         seen_ff       <= 1'b0;
         any_commit_ff <= 1'b0;
         committed_ff  <= BAND_NORMAL;
         phase_ff      <= '0;
         head_ff       <= '0;
         count_ff      <= '0;
      end else begin
         if (cmd.first_beat) begin
            seen_ff      <= 1'b1;
            sec_start_ff <= item_time_ff;
            sec_band_ff  <= item_band_ff;
            settled_ff   <= 1'b1;
         end
         if (cmd.new_section) begin
            sec_start_ff <= item_time_ff;
            sec_band_ff  <= item_band_ff;
            settled_ff   <= 1'b0;
         end
         if (cmd.merge_section) begin
            sec_band_ff <= committed_ff;
         end
         if (cmd.set_settled) begin
            settled_ff <= 1'b1;
         end
         if (cmd.write_beat) begin
            count_ff <= count_ff + CNT_W'(1);
            if (sec_len >= min_sec_ff) begin
               settled_ff <= 1'b1;
            end
         end
         if (cmd.commit) begin
            phase_ff      <= ph_c;
            committed_ff  <= c_band;
            any_commit_ff <= 1'b1;
            head_ff       <= head_next;
            count_ff      <= count_ff - CNT_W'(1);
         end
      end
   end

   // pending store memory with registered head read
   always_ff @(posedge clock) begin
      if (cmd.write_beat) begin
         pend_time_ff[tail] <= item_time_ff;
         pend_band_ff[tail] <= item_band_ff;
      end
      rd_time_ff <= pend_time_ff[head_ff];
      rd_band_ff <= pend_band_ff[head_ff];
   end

   // held word and output register control
   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.commit && c_keep) begin
            held_valid_ff <= 1'b1;
         end else if (cmd.flush_held) begin
            held_valid_ff <= 1'b0;
         end
         if ((cmd.commit && c_keep && held_valid_ff) || cmd.flush_held) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // held word and output register payload
   always_ff @(posedge clock) begin
      if (cmd.commit && c_keep) begin
         held_time_ff <= rd_time_ff;
         held_band_ff <= c_band;
      end
      if ((cmd.commit && c_keep && held_valid_ff) || cmd.flush_held) begin
         rsp_time_ff <= held_time_ff;
         rsp_band_ff <= held_band_ff;
         rsp_end_ff  <= cmd.flush_held;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kept_time = rsp_time_ff;
   assign rsp_kept_band = rsp_band_ff;
   assign rsp_run_end   = rsp_end_ff;

endmodule

`default_nettype wire
